// ----- rtl/tsf_pkg.sv -----
`timescale 1ns / 1ps

package tsf_pkg;

  // Sample width of voltage and current.
  localparam int SAMPLE_WIDTH = 24;

  // Weighted sums carry at most weight 9: four extra bits, signed.
  localparam int SUM_WIDTH  = SAMPLE_WIDTH + 4;
  localparam int MAG_WIDTH  = SAMPLE_WIDTH + 3;

  // Each divider cell resolves this many quotient bits.
  localparam int CELL_BITS  = 4;
  localparam int DIV_CELLS  = (MAG_WIDTH + CELL_BITS - 1) / CELL_BITS;
  localparam int WORK_WIDTH = DIV_CELLS * CELL_BITS;

  // Divisors are at most 9, so remainders fit in four bits.
  localparam int REM_WIDTH  = 4;

  localparam int TAPS       = 5;
  localparam int POS_WIDTH  = 3;
  localparam int JOB_WIDTH  = 2;

  // Frame position codes (saturating at POS_INTERIOR).
  localparam logic [POS_WIDTH-1:0] POS_FIRST    = 3'd0;
  localparam logic [POS_WIDTH-1:0] POS_SECOND   = 3'd1;
  localparam logic [POS_WIDTH-1:0] POS_THIRD    = 3'd2;
  localparam logic [POS_WIDTH-1:0] POS_FOURTH   = 3'd3;
  localparam logic [POS_WIDTH-1:0] POS_INTERIOR = 3'd4;

  // Result slots of one transfer, oldest sample first.
  localparam logic [JOB_WIDTH-1:0] JOB_OLDEST = 2'd0;
  localparam logic [JOB_WIDTH-1:0] JOB_MIDDLE = 2'd1;
  localparam logic [JOB_WIDTH-1:0] JOB_NEWEST = 2'd2;

  localparam logic [REM_WIDTH-1:0] DIVISOR_1 = 4'd1;
  localparam logic [REM_WIDTH-1:0] DIVISOR_6 = 4'd6;
  localparam logic [REM_WIDTH-1:0] DIVISOR_8 = 4'd8;
  localparam logic [REM_WIDTH-1:0] DIVISOR_9 = 4'd9;

  typedef enum logic [2:0] {
    KIND_RAW,
    KIND_START6,
    KIND_START8,
    KIND_MID9,
    KIND_END8,
    KIND_END6
  } kind_e;

  // One result travelling through the divider chain.
  typedef struct packed {
    logic [WORK_WIDTH-1:0]          work;
    logic [REM_WIDTH-1:0]           rem;
    logic [REM_WIDTH-1:0]           divisor;
    logic                           neg;
    logic signed [SAMPLE_WIDTH-1:0] current;
    logic                           frame_last;
    logic                           run_last;
    logic                           short_frame;
  } div_job_t;

endpackage

// ----- rtl/tsf_if.sv -----
`timescale 1ns / 1ps

interface tsf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] voltage;
  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] current;
  logic                                    frame_end;

  modport source (output valid, voltage, current, frame_end, input ready);
  modport sink   (input valid, voltage, current, frame_end, output ready);
endinterface

interface tsf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] smoothed_voltage;
  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] current_out;
  logic                                    frame_last;
  logic                                    run_last;
  logic                                    short_frame;

  modport source (output valid, smoothed_voltage, current_out, frame_last, run_last,
                  short_frame, input ready);
  modport sink   (input valid, smoothed_voltage, current_out, frame_last, run_last,
                  short_frame, output ready);
endinterface

// ----- rtl/tsf_tap_cell.sv -----
`timescale 1ns / 1ps

// One sample slot of the window; passes its contents to the older neighbor.
module tsf_tap_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    shift_i,
  input  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] voltage_i,
  input  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] current_i,
  output logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] voltage_o,
  output logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] current_o
);

  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] voltage_q, voltage_d;
  logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] current_q, current_d;

  always_comb begin
    voltage_d = voltage_q;
    current_d = current_q;
    if (shift_i) begin
      voltage_d = voltage_i;
      current_d = current_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voltage_q <= '0;
      current_q <= '0;
    end else begin
      voltage_q <= voltage_d;
      current_q <= current_d;
    end
  end

  assign voltage_o = voltage_q;
  assign current_o = current_q;

endmodule

// ----- rtl/tsf_div_cell.sv -----
`timescale 1ns / 1ps

// Restoring division by a small constant, CELL_BITS quotient bits per cell.
// The work word shifts dividend bits out at the top and quotient bits in at
// the bottom.
module tsf_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tsf_pkg::div_job_t   job_i,
  output logic                ready_o,
  output logic                valid_o,
  output tsf_pkg::div_job_t   job_o,
  input  logic                ready_i
);

  logic                                valid_q, valid_d;
  tsf_pkg::div_job_t                   job_q, job_d;
  logic [tsf_pkg::WORK_WIDTH-1:0]      work;
  logic [tsf_pkg::REM_WIDTH-1:0]       rem;
  logic [tsf_pkg::REM_WIDTH:0]         trial;
  logic                                load;

  always_comb begin
    work  = job_i.work;
    rem   = job_i.rem;
    trial = '0;
    for (int b = 0; b < tsf_pkg::CELL_BITS; b++) begin
      trial = {rem, work[tsf_pkg::WORK_WIDTH-1]};
      work  = {work[tsf_pkg::WORK_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, job_i.divisor}) begin
        rem     = tsf_pkg::REM_WIDTH'(trial - {1'b0, job_i.divisor});
        work[0] = 1'b1;
      end else begin
        rem = trial[tsf_pkg::REM_WIDTH-1:0];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
    job_d = job_q;
    if (load) begin
      job_d      = job_i;
      job_d.work = work;
      job_d.rem  = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;

endmodule

// ----- rtl/triangular_smoothing_filter_unit.sv -----
`timescale 1ns / 1ps

// Triangular 1-2-3-2-1 smoothing of the voltage in (voltage, current) frames, with
// shortened windows at both frame edges and pass-through of frames under four samples.
// Input transfers are taken one per cycle while the divider chain takes jobs; an item
// with frame_end set produces three results (one per sample in a frame of one or two
// samples) and holds off input until its last result has entered the divider chain, since
// all results enter the chain through one job port, one per cycle while it is not stalled.
// A result goes from the window cells through the weighted sum into the first divider
// cell, then through each of the DIV_CELLS divider cells and the output register.
// Input is still taken while a finished result waits at the output, until the chain
// has filled up.
module triangular_smoothing_filter_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  tsf_in_if.sink           in_i,
  tsf_out_if.source        out_o
);

  localparam int SW = tsf_pkg::SAMPLE_WIDTH;
  localparam int NC = tsf_pkg::DIV_CELLS;

  // Window cells, index TAPS-1 holds the newest sample.
  logic signed [SW-1:0] tap_v [tsf_pkg::TAPS];
  logic signed [SW-1:0] tap_c [tsf_pkg::TAPS];

  logic                                 accept;
  logic                                 issue;
  logic                                 final_job;
  logic                                 produces;

  logic [tsf_pkg::POS_WIDTH-1:0]        pos_q, pos_d;
  logic                                 act_q, act_d;
  logic [tsf_pkg::JOB_WIDTH-1:0]        jsel_q, jsel_d;
  logic                                 last_q, last_d;
  logic [tsf_pkg::POS_WIDTH-1:0]        pos_at_q, pos_at_d;

  logic                                 short_job;
  tsf_pkg::kind_e                       kind;
  logic [tsf_pkg::POS_WIDTH-1:0]        sel_tap;
  logic signed [tsf_pkg::SUM_WIDTH-1:0] ext [tsf_pkg::TAPS];
  logic signed [tsf_pkg::SUM_WIDTH-1:0] sum;
  logic signed [tsf_pkg::SUM_WIDTH-1:0] sum_abs;
  tsf_pkg::div_job_t                    job;

  logic              div_valid [NC+1];
  logic              div_ready [NC+1];
  tsf_pkg::div_job_t div_job   [NC+1];

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic              out_stage_ready;
  logic [SW-1:0]     quot;
  logic signed [SW-1:0] volt_q, volt_d;
  logic signed [SW-1:0] cur_q;
  logic              fl_q, rl_q, sf_q;

  // ---------------------------------------------------------------- window
  for (genvar k = 0; k < tsf_pkg::TAPS; k++) begin : g_tap
    if (k == tsf_pkg::TAPS - 1) begin : g_head
      tsf_tap_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (accept),
        .voltage_i (in_i.voltage),
        .current_i (in_i.current),
        .voltage_o (tap_v[k]),
        .current_o (tap_c[k])
      );
    end else begin : g_body
      tsf_tap_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (accept),
        .voltage_i (tap_v[k+1]),
        .current_i (tap_c[k+1]),
        .voltage_o (tap_v[k]),
        .current_o (tap_c[k])
      );
    end
  end

  // ---------------------------------------------------------------- job sequencer
  // A job is pending while act_q is set; the window holds still until the
  // last job of the transfer has gone into the divider chain.
  assign issue      = act_q && div_ready[0];
  assign final_job  = !last_q || (jsel_q == tsf_pkg::JOB_NEWEST);
  assign in_i.ready = !act_q || (issue && final_job);
  assign accept     = in_i.valid && in_i.ready;
  assign produces   = in_i.frame_end || (pos_q >= tsf_pkg::POS_THIRD);

  always_comb begin
    pos_d    = pos_q;
    act_d    = act_q;
    jsel_d   = jsel_q;
    last_d   = last_q;
    pos_at_d = pos_at_q;
    if (issue) begin
      if (final_job) begin
        act_d = 1'b0;
      end else begin
        jsel_d = jsel_q + 1'b1;
      end
    end
    if (accept) begin
      act_d    = produces;
      last_d   = in_i.frame_end;
      pos_at_d = pos_q;
      jsel_d   = tsf_pkg::JOB_OLDEST;
      if (in_i.frame_end) begin
        // A short frame only has as many results as samples.
        if (pos_q == tsf_pkg::POS_FIRST) begin
          jsel_d = tsf_pkg::JOB_NEWEST;
        end else if (pos_q == tsf_pkg::POS_SECOND) begin
          jsel_d = tsf_pkg::JOB_MIDDLE;
        end
      end
      if (in_i.frame_end) begin
        pos_d = tsf_pkg::POS_FIRST;
      end else if (pos_q < tsf_pkg::POS_INTERIOR) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= tsf_pkg::POS_FIRST;
      act_q    <= 1'b0;
      jsel_q   <= tsf_pkg::JOB_OLDEST;
      last_q   <= 1'b0;
      pos_at_q <= tsf_pkg::POS_FIRST;
    end else begin
      pos_q    <= pos_d;
      act_q    <= act_d;
      jsel_q   <= jsel_d;
      last_q   <= last_d;
      pos_at_q <= pos_at_d;
    end
  end

  // ---------------------------------------------------------------- weighted sum
  assign short_job = last_q && (pos_at_q < tsf_pkg::POS_FOURTH);
  assign sel_tap   = {1'b0, jsel_q} + tsf_pkg::POS_WIDTH'(2);

  always_comb begin
    if (short_job) begin
      kind = tsf_pkg::KIND_RAW;
    end else if (last_q) begin
      case (jsel_q)
        tsf_pkg::JOB_OLDEST: kind = (pos_at_q == tsf_pkg::POS_FOURTH) ?
                                    tsf_pkg::KIND_START8 : tsf_pkg::KIND_MID9;
        tsf_pkg::JOB_MIDDLE: kind = tsf_pkg::KIND_END8;
        default:             kind = tsf_pkg::KIND_END6;
      endcase
    end else begin
      case (pos_at_q)
        tsf_pkg::POS_THIRD:  kind = tsf_pkg::KIND_START6;
        tsf_pkg::POS_FOURTH: kind = tsf_pkg::KIND_START8;
        default:             kind = tsf_pkg::KIND_MID9;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < tsf_pkg::TAPS; k++) begin
      ext[k] = tsf_pkg::SUM_WIDTH'(tap_v[k]);
    end
  end

  always_comb begin
    job = '0;
    case (kind)
      tsf_pkg::KIND_START6: begin
        sum         = (ext[2] <<< 1) + ext[2] + (ext[3] <<< 1) + ext[4];
        job.divisor = tsf_pkg::DIVISOR_6;
      end
      tsf_pkg::KIND_START8: begin
        sum         = (ext[1] <<< 1) + (ext[2] <<< 1) + ext[2] + (ext[3] <<< 1) + ext[4];
        job.divisor = tsf_pkg::DIVISOR_8;
      end
      tsf_pkg::KIND_MID9: begin
        sum         = ext[0] + (ext[1] <<< 1) + (ext[2] <<< 1) + ext[2]
                      + (ext[3] <<< 1) + ext[4];
        job.divisor = tsf_pkg::DIVISOR_9;
      end
      tsf_pkg::KIND_END8: begin
        sum         = ext[1] + (ext[2] <<< 1) + (ext[3] <<< 1) + ext[3] + (ext[4] <<< 1);
        job.divisor = tsf_pkg::DIVISOR_8;
      end
      tsf_pkg::KIND_END6: begin
        sum         = ext[2] + (ext[3] <<< 1) + (ext[4] <<< 1) + ext[4];
        job.divisor = tsf_pkg::DIVISOR_6;
      end
      default: begin
        sum         = ext[sel_tap];
        job.divisor = tsf_pkg::DIVISOR_1;
      end
    endcase
    sum_abs         = sum[tsf_pkg::SUM_WIDTH-1] ? -sum : sum;
    job.neg         = sum[tsf_pkg::SUM_WIDTH-1];
    job.work        = tsf_pkg::WORK_WIDTH'(sum_abs[tsf_pkg::MAG_WIDTH-1:0]);
    job.rem         = '0;
    job.current     = tap_c[sel_tap];
    job.frame_last  = last_q && (jsel_q == tsf_pkg::JOB_NEWEST);
    job.run_last    = final_job;
    job.short_frame = short_job;
  end

  // ---------------------------------------------------------------- divider chain
  assign div_valid[0] = act_q;
  assign div_job[0]   = job;

  for (genvar k = 0; k < NC; k++) begin : g_div
    tsf_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .job_i   (div_job[k]),
      .ready_o (div_ready[k]),
      .valid_o (div_valid[k+1]),
      .job_o   (div_job[k+1]),
      .ready_i (div_ready[k+1])
    );
  end

  // ---------------------------------------------------------------- output register
  assign out_stage_ready = !out_valid_q || out_o.ready;
  assign div_ready[NC]   = out_stage_ready;
  assign out_load        = div_valid[NC] && out_stage_ready;
  assign quot            = div_job[NC].work[SW-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_stage_ready) begin
      out_valid_d = div_valid[NC];
    end
    // Sign restored after dividing the magnitude: truncation toward zero.
    volt_d = div_job[NC].neg ? -$signed(quot) : $signed(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      volt_q <= volt_d;
      cur_q  <= div_job[NC].current;
      fl_q   <= div_job[NC].frame_last;
      rl_q   <= div_job[NC].run_last;
      sf_q   <= div_job[NC].short_frame;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.smoothed_voltage = volt_q;
  assign out_o.current_out      = cur_q;
  assign out_o.frame_last       = fl_q;
  assign out_o.run_last         = rl_q;
  assign out_o.short_frame      = sf_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [tsf_pkg::SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t voltage;
    sample_t current;
    logic    frame_last;
    logic    run_last;
    logic    short_frame;
  } smooth_res_t;

  typedef struct packed {
    sample_t     voltage;
    sample_t     current;
    logic        frame_end;
    logic        typed;
    smooth_res_t want;
  } stim_row_t;

  localparam sample_t S_MAX = {1'b0, {(tsf_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(tsf_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam int N_DIRECTED = 24;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tsf_in_if  in_if ();
  tsf_out_if out_if ();

  triangular_smoothing_filter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  sample_t                        vhist [4];
  sample_t                        chist [2];
  logic [tsf_pkg::POS_WIDTH-1:0]  frame_pos;
  smooth_res_t                    step_out [$];
  smooth_res_t                    pending_samples [$];

  int tx_idle_pct = 35;
  int rx_idle_pct = 57;
  int hold_asks = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int short_frames = 0;
  int results_seen = 0;
  int cycle_count = 0;

  stim_row_t   directed [N_DIRECTED];
  smooth_res_t mon_got;
  smooth_res_t mon_want;

  function automatic sample_t scaled(longint sum, logic [tsf_pkg::REM_WIDTH-1:0] d);
    return sample_t'(sum / longint'(d));
  endfunction

  function automatic void note_result(sample_t v, sample_t c, logic fl, logic rl, logic sf);
    smooth_res_t r;
    r.voltage     = v;
    r.current     = c;
    r.frame_last  = fl;
    r.run_last    = rl;
    r.short_frame = sf;
    step_out.push_back(r);
  endfunction

  // Advance the smoother by one sample; results land in step_out.
  function automatic void smooth_step(sample_t v, sample_t c, logic fe);
    longint  x0, x1, x2, x3, xn;
    sample_t head;
    x0 = vhist[0];
    x1 = vhist[1];
    x2 = vhist[2];
    x3 = vhist[3];
    xn = v;
    step_out.delete();
    if (fe) begin
      case (frame_pos)
        tsf_pkg::POS_FIRST: begin
          note_result(v, c, 1'b1, 1'b1, 1'b1);
        end
        tsf_pkg::POS_SECOND: begin
          note_result(vhist[3], chist[1], 1'b0, 1'b0, 1'b1);
          note_result(v, c, 1'b1, 1'b1, 1'b1);
        end
        tsf_pkg::POS_THIRD: begin
          note_result(vhist[2], chist[0], 1'b0, 1'b0, 1'b1);
          note_result(vhist[3], chist[1], 1'b0, 1'b0, 1'b1);
          note_result(v, c, 1'b1, 1'b1, 1'b1);
        end
        default: begin
          if (frame_pos == tsf_pkg::POS_FOURTH) begin
            head = scaled(2*x1 + 3*x2 + 2*x3 + xn, tsf_pkg::DIVISOR_8);
          end else begin
            head = scaled(x0 + 2*x1 + 3*x2 + 2*x3 + xn, tsf_pkg::DIVISOR_9);
          end
          note_result(head, chist[0], 1'b0, 1'b0, 1'b0);
          note_result(scaled(x1 + 2*x2 + 3*x3 + 2*xn, tsf_pkg::DIVISOR_8), chist[1],
                      1'b0, 1'b0, 1'b0);
          note_result(scaled(x2 + 2*x3 + 3*xn, tsf_pkg::DIVISOR_6), c, 1'b1, 1'b1, 1'b0);
        end
      endcase
    end else if (frame_pos >= tsf_pkg::POS_THIRD) begin
      if (frame_pos == tsf_pkg::POS_THIRD) begin
        head = scaled(3*x2 + 2*x3 + xn, tsf_pkg::DIVISOR_6);
      end else if (frame_pos == tsf_pkg::POS_FOURTH) begin
        head = scaled(2*x1 + 3*x2 + 2*x3 + xn, tsf_pkg::DIVISOR_8);
      end else begin
        head = scaled(x0 + 2*x1 + 3*x2 + 2*x3 + xn, tsf_pkg::DIVISOR_9);
      end
      note_result(head, chist[0], 1'b0, 1'b1, 1'b0);
    end
    vhist[0] = vhist[1];
    vhist[1] = vhist[2];
    vhist[2] = vhist[3];
    vhist[3] = v;
    chist[0] = chist[1];
    chist[1] = c;
    if (fe) begin
      frame_pos = tsf_pkg::POS_FIRST;
    end else if (frame_pos != tsf_pkg::POS_INTERIOR) begin
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s on result %0d: got %0d, expected %0d", field, results_seen, got,
             want);
    mismatch_count++;
  endtask

  // Entered and left at a rising edge; leaves at the edge of the transfer.
  task automatic send_item(sample_t v, sample_t c, logic fe, logic typed, smooth_res_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.voltage   <= v;
    in_if.current   <= c;
    in_if.frame_end <= fe;
    do @(negedge clk_i); while (!in_if.ready);
    if (fe) begin
      frames_sent++;
      if (frame_pos < tsf_pkg::POS_FOURTH) short_frames++;
    end
    smooth_step(v, c, fe);
    if (typed) begin
      pending_samples.push_back(want);
    end else begin
      foreach (step_out[k]) pending_samples.push_back(step_out[k]);
    end
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic sample_t rand_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return S_MAX;
    if (roll < 20) return S_MIN;
    if (roll < 40) return sample_t'($urandom_range(40)) - sample_t'(20);
    return sample_t'($urandom);
  endfunction

  task automatic random_frame(int len);
    for (int k = 0; k < len; k++) begin
      send_item(rand_sample(), rand_sample(), k == len - 1, 1'b0, '0);
    end
  endtask

  task automatic random_phase();
    int stop_at;
    int roll;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 12) random_frame($urandom_range(3, 1));
      else if (roll < 90) random_frame($urandom_range(12, 4));
      else random_frame($urandom_range(40, 13));
    end
  endtask

  // Sink side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output checks; a transfer seen at the falling edge completes at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      mon_got.voltage     = out_if.smoothed_voltage;
      mon_got.current     = out_if.current_out;
      mon_got.frame_last  = out_if.frame_last;
      mon_got.run_last    = out_if.run_last;
      mon_got.short_frame = out_if.short_frame;
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result, voltage", mon_got.voltage, 0);
      end else begin
        mon_want = pending_samples.pop_front();
        if (mon_got.voltage !== mon_want.voltage)
          report_mismatch("smoothed_voltage", mon_got.voltage, mon_want.voltage);
        if (mon_got.current !== mon_want.current)
          report_mismatch("current_out", mon_got.current, mon_want.current);
        if (mon_got.frame_last !== mon_want.frame_last)
          report_mismatch("frame_last", mon_got.frame_last, mon_want.frame_last);
        if (mon_got.run_last !== mon_want.run_last)
          report_mismatch("run_last", mon_got.run_last, mon_want.run_last);
        if (mon_got.short_frame !== mon_want.short_frame)
          report_mismatch("short_frame", mon_got.short_frame, mon_want.short_frame);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_samples.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_if.valid     <= 1'b0;
    in_if.voltage   <= '0;
    in_if.current   <= '0;
    in_if.frame_end <= 1'b0;
    foreach (vhist[k]) vhist[k] = '0;
    foreach (chist[k]) chist[k] = '0;
    frame_pos = tsf_pkg::POS_FIRST;

    // single-sample frames at the extremes pass through raw
    directed[0]  = '{S_MAX, S_MIN, 1'b1, 1'b1, '{S_MAX, S_MIN, 1'b1, 1'b1, 1'b1}};
    directed[1]  = '{S_MIN, S_MAX, 1'b1, 1'b1, '{S_MIN, S_MAX, 1'b1, 1'b1, 1'b1}};
    // two- and three-sample short frames
    directed[2]  = '{sample_t'(5), sample_t'(-3), 1'b0, 1'b0, '0};
    directed[3]  = '{sample_t'(-7), sample_t'(9), 1'b1, 1'b0, '0};
    directed[4]  = '{sample_t'(1000), sample_t'(1), 1'b0, 1'b0, '0};
    directed[5]  = '{sample_t'(-2000), sample_t'(2), 1'b0, 1'b0, '0};
    directed[6]  = '{sample_t'(3000), sample_t'(3), 1'b1, 1'b0, '0};
    // four-sample frame: start and end windows meet
    directed[7]  = '{sample_t'(100), sample_t'(-50), 1'b0, 1'b0, '0};
    directed[8]  = '{sample_t'(-51), sample_t'(60), 1'b0, 1'b0, '0};
    directed[9]  = '{sample_t'(77), sample_t'(-70), 1'b0, 1'b0, '0};
    directed[10] = '{sample_t'(-1), sample_t'(80), 1'b1, 1'b0, '0};
    // constant full-scale frame: every window averages back to full scale
    directed[11] = '{S_MAX, S_MIN, 1'b0, 1'b0, '0};
    directed[12] = '{S_MAX, S_MIN, 1'b0, 1'b0, '0};
    for (int k = 13; k <= 16; k++) begin
      directed[k] = '{S_MAX, S_MIN, 1'b0, 1'b1, '{S_MAX, S_MIN, 1'b0, 1'b1, 1'b0}};
    end
    directed[17] = '{S_MAX, S_MIN, 1'b1, 1'b0, '0};
    // mixed signs, truncation of negative sums toward zero
    directed[18] = '{S_MIN, sample_t'(11), 1'b0, 1'b0, '0};
    directed[19] = '{S_MAX, sample_t'(-12), 1'b0, 1'b0, '0};
    directed[20] = '{sample_t'(-5), sample_t'(13), 1'b0, 1'b0, '0};
    directed[21] = '{sample_t'(3), sample_t'(-14), 1'b0, 1'b0, '0};
    directed[22] = '{sample_t'(-1), sample_t'(15), 1'b0, 1'b0, '0};
    directed[23] = '{S_MIN, sample_t'(-16), 1'b1, 1'b0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      send_item(directed[k].voltage, directed[k].current, directed[k].frame_end,
                directed[k].typed, directed[k].want);
    end
    wait_drain();

    // sink holds off while a long frame streams in back to back
    hold_asks++;
    tx_idle_pct = 0;
    random_frame(40);
    tx_idle_pct = 35;
    wait_drain();

    random_phase();
    wait_drain();

    tx_idle_pct = 57;
    rx_idle_pct = 35;
    random_phase();
    wait_drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase();
    wait_drain();
    repeat (20) @(posedge clk_i);

    $display("covered %0d input transfers in %0d frames (%0d short), %0d results checked",
             items_sent, frames_sent, short_frames, results_seen);
    $display("ran sender/receiver stall mixes 35/57, 57/35 and none, plus a long sink hold");
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- triangular_smoothing_filter_unit.f -----
rtl/tsf_pkg.sv
rtl/tsf_if.sv
rtl/tsf_tap_cell.sv
rtl/tsf_div_cell.sv
rtl/triangular_smoothing_filter_unit.sv
tb/sv/testbench.sv
